/* rtl/bts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, constants and the glyph width table for the text sprite layout.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int POS_W       = 12;
    localparam int FONT_W      = 32;
    localparam int CODE_W      = 8;
    localparam int GLYPH_W     = 7;
    localparam int WIDTH_W     = 4;
    localparam int COLOUR_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int TEX_U_W     = 7;
    localparam int TEX_V_W     = 8;

    localparam int GLYPH_COUNT = 104;
    localparam int TABLE_DEPTH = 104;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_WORD = 2'd2;

    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

    localparam logic [CODE_W-1:0] FIRST_GLYPH_CODE = 8'd32;
    localparam logic [CODE_W:0]   GLYPH_END_CODE   = 9'(32 + GLYPH_COUNT);

    localparam logic [POS_W-1:0] TAB_STEP   = 12'd64;
    localparam logic [POS_W-1:0] TAB_MASK   = 12'hfc0;
    localparam logic [POS_W-1:0] TAB_LIMIT  = 12'd512;
    localparam logic [POS_W-1:0] LINE_STEP  = 12'd12;
    localparam logic [POS_W-1:0] SPACE_STEP = 12'd6;

    localparam logic [GLYPH_W-1:0]  GREY_LOW   = 7'd96;
    localparam logic [GLYPH_W-1:0]  GREY_HIGH  = 7'd99;
    localparam logic [COLOUR_W-1:0] GREY       = 8'd128;
    localparam logic [TEX_U_W-1:0]  CELL_U     = 7'd12;
    localparam logic [TEX_V_W-1:0]  CELL_V     = 8'd12;

    localparam logic [WIDTH_W-1:0] GLYPH_WIDTHS [0:TABLE_DEPTH-1] = '{
        4'd5, 4'd2, 4'd7, 4'd7, 4'd7, 4'd10, 4'd9, 4'd5,
        4'd3, 4'd3, 4'd5, 4'd6, 4'd3, 4'd4, 4'd3, 4'd3,
        4'd7, 4'd5, 4'd7, 4'd7, 4'd8, 4'd7, 4'd7, 4'd6,
        4'd7, 4'd7, 4'd3, 4'd3, 4'd6, 4'd6, 4'd6, 4'd7,
        4'd9, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd8,
        4'd8, 4'd3, 4'd7, 4'd9, 4'd6, 4'd9, 4'd8, 4'd8,
        4'd7, 4'd8, 4'd8, 4'd7, 4'd9, 4'd8, 4'd9, 4'd11,
        4'd9, 4'd9, 4'd7, 4'd4, 4'd3, 4'd4, 4'd6, 4'd6,
        4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd7,
        4'd7, 4'd3, 4'd4, 4'd8, 4'd3, 4'd11, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd5, 4'd6, 4'd5, 4'd7, 4'd7, 4'd11,
        4'd7, 4'd7, 4'd6, 4'd4, 4'd2, 4'd4, 4'd6, 4'd8,
        4'd12, 4'd12, 4'd12, 4'd12, 4'd11, 4'd11, 4'd11, 4'd11
    };

    typedef struct packed {
        logic [POS_W-1:0]  origin_x;
        logic [POS_W-1:0]  origin_y;
        logic [FONT_W-1:0] font_word;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]    sprite_x;
        logic [POS_W-1:0]    sprite_y;
        logic [WIDTH_W-1:0]  glyph_width;
        logic [TEX_U_W-1:0]  tex_u;
        logic [TEX_V_W-1:0]  tex_v;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                semi_transparent;
    } sprite_t;

    function automatic logic [WIDTH_W-1:0] glyph_width_f(input logic [GLYPH_W-1:0] g);
        logic [WIDTH_W-1:0] w;
        begin
            w = '0;
            if (int'(g) < TABLE_DEPTH)
            begin
                w = GLYPH_WIDTHS[g];
            end
            return w;
        end
    endfunction

endpackage

/* rtl/bts_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_cfg_regs
// Configuration register file: origin and font word, write only.
// ----------------------------------------------------------------------------
module bts_cfg_regs
    import bts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FONT_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:  cfg_next.origin_x  = cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:  cfg_next.origin_y  = cfg_data[POS_W-1:0];
                REG_FONT_WORD: cfg_next.font_word = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/bts_layout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_layout
// Input register, pen state, glyph decode and result register.
// ----------------------------------------------------------------------------
module bts_layout
    import bts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic [CODE_W-1:0] char_code,
    input  logic              first_char,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output sprite_t           res
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CODE_W-1:0] code_reg;
    logic              first_reg;
    logic [POS_W-1:0]  pen_x_reg;
    logic [POS_W-1:0]  pen_x_next;
    logic [POS_W-1:0]  pen_y_reg;
    logic [POS_W-1:0]  pen_y_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sprite_t           res_reg;
    sprite_t           res_next;

    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   tab_x;
    logic [CODE_W-1:0]  g_full;
    logic [GLYPH_W-1:0] g;
    logic [WIDTH_W-1:0] w;
    logic               is_glyph;
    logic               tinted;
    logic               advance;
    logic               in_take;

    always_comb
    begin
        px       = first_reg ? cfg.origin_x : pen_x_reg;
        py       = first_reg ? cfg.origin_y : pen_y_reg;
        tab_x    = (px + TAB_STEP) & TAB_MASK;
        g_full   = code_reg - FIRST_GLYPH_CODE;
        g        = g_full[GLYPH_W-1:0];
        w        = glyph_width_f(g);
        is_glyph = (code_reg > FIRST_GLYPH_CODE) && ({1'b0, code_reg} < GLYPH_END_CODE);
        tinted   = (cfg.font_word != '0) && ((g < GREY_LOW) || (g > GREY_HIGH));

        pen_x_next = px;
        pen_y_next = py;
        priority if (code_reg == CODE_TAB)
        begin
            if (tab_x > TAB_LIMIT)
            begin
                pen_x_next = cfg.origin_x;
                pen_y_next = py + LINE_STEP;
            end
            else
            begin
                pen_x_next = tab_x;
            end
        end
        else if ((code_reg == CODE_LF) || (code_reg == CODE_CR))
        begin
            pen_x_next = cfg.origin_x;
            pen_y_next = py + LINE_STEP;
        end
        else if (code_reg == CODE_SPACE)
        begin
            pen_x_next = px + SPACE_STEP;
        end
        else if (is_glyph)
        begin
            pen_x_next = px + POS_W'(w) + POS_W'(1);
        end
        else
        begin
            pen_x_next = px;
        end

        res_next.sprite_x    = px;
        res_next.sprite_y    = py;
        res_next.glyph_width = w;
        res_next.tex_u       = TEX_U_W'(g[2:0]) * CELL_U;
        res_next.tex_v       = TEX_V_W'(g[GLYPH_W-1:3]) * CELL_V;
        if (tinted)
        begin
            res_next.red              = cfg.font_word[23:16];
            res_next.green            = cfg.font_word[15:8];
            res_next.blue             = cfg.font_word[7:0];
            res_next.semi_transparent = (cfg.font_word[31:24] != '0);
        end
        else
        begin
            res_next.red              = GREY;
            res_next.green            = GREY;
            res_next.blue             = GREY;
            res_next.semi_transparent = 1'b0;
        end
    end

    // advance the held item unless its sprite would overwrite a stalled result
    assign advance  = s1_valid_reg && (!is_glyph || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && is_glyph)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pen_x_reg <= pen_x_next;
                pen_y_reg <= pen_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            code_reg  <= char_code;
            first_reg <= first_char;
        end
        if (advance && is_glyph)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/bitmap_text_sprite_layout_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_sprite_layout_top
// Lays out a byte stream of text as glyph sprites from a running pen.
// ----------------------------------------------------------------------------
// Input channel: char_code and first_char, moved by in_valid / in_stall.
// Output channel: one sprite item per printable glyph, moved by out_valid /
// out_stall. Tab, LF, CR and space move the pen and give no item; codes
// without a glyph give nothing and leave the pen alone.
// Configuration: cfg_we, cfg_index, cfg_data write origin_x, origin_y and
// font_word; write only while no item is in flight.
// Path: a sprite passes the input register, then the result register, which
// drives the outputs. Throughput: one byte per cycle while in_stall is low,
// set by the single pen update between the two registers.
// Reset clears the pen, cfg and both valid flags, not the input or result
// register. While the receiver stalls, the result holds; the next byte still
// enters the input register, and a byte that gives no sprite still advances.
// in_stall rises only when a held glyph meets a full, stalled result register.
// ----------------------------------------------------------------------------
module bitmap_text_sprite_layout_top
    import bts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FONT_W-1:0]    cfg_data,
    input  logic [CODE_W-1:0]    char_code,
    input  logic                 first_char,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic [POS_W-1:0]     sprite_x,
    output logic [POS_W-1:0]     sprite_y,
    output logic [WIDTH_W-1:0]   glyph_width,
    output logic [TEX_U_W-1:0]   tex_u,
    output logic [TEX_V_W-1:0]   tex_v,
    output logic [COLOUR_W-1:0]  red,
    output logic [COLOUR_W-1:0]  green,
    output logic [COLOUR_W-1:0]  blue,
    output logic                 semi_transparent,
    output logic                 out_valid,
    input  logic                 out_stall
);

    cfg_t    cfg;
    sprite_t res;

    bts_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bts_layout u_layout
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_code  (char_code),
        .first_char (first_char),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign sprite_x         = res.sprite_x;
    assign sprite_y         = res.sprite_y;
    assign glyph_width      = res.glyph_width;
    assign tex_u            = res.tex_u;
    assign tex_v            = res.tex_v;
    assign red              = res.red;
    assign green            = res.green;
    assign blue             = res.blue;
    assign semi_transparent = res.semi_transparent;

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty result register");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid)
        else $error("result dropped while input was stalled");

    a_grey_not_translucent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (tex_v == 8'd144) && (tex_u <= 7'd36)) |-> !semi_transparent)
        else $error("grey glyph marked semi-transparent");

endmodule
